>>> rtl/ffse_pkg.sv
// Package: shared types, codes and sizes for the FASTA/FASTQ sequence extractor.
package ffse_pkg;

  localparam int unsigned LengthBits = 32;
  localparam int unsigned OutLenW    = 32;
  localparam int unsigned QDepth     = 2;
  localparam int unsigned QPtrW      = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int unsigned QCntW      = $clog2(QDepth + 1);

  localparam logic [7:0] ChGt = 8'h3e;
  localparam logic [7:0] ChAt = 8'h40;
  localparam logic [7:0] ChLf = 8'h0a;
  localparam logic [7:0] ChCr = 8'h0d;

  typedef enum logic [1:0] {
    KIND_BASE   = 2'd0,
    KIND_RECEND = 2'd1,
    KIND_STATUS = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_UNKNOWN = 2'd1,
    ST_EMPTY   = 2'd2,
    ST_TRUNC   = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    PH_HEADER   = 2'd0,
    PH_EOL_HDR  = 2'd1,
    PH_READ     = 2'd2,
    PH_EOL_READ = 2'd3
  } fa_phase_e;

  typedef enum logic [1:0] {
    FQ_HEADER = 2'd0,
    FQ_SEQ    = 2'd1,
    FQ_PLUS   = 2'd2,
    FQ_QUAL   = 2'd3
  } fq_line_e;

  // One classified word as it travels from the front to the back.
  typedef struct packed {
    logic [7:0] data;
    logic       eoi;
    logic       eol;
    logic       gt;
    logic       at;
  } item_t;

  typedef struct packed {
    logic    base;
    logic    rec_end;
    logic    stat;
    status_e code;
  } action_t;

  function automatic logic [OutLenW-1:0] clip_len(input logic [LengthBits-1:0] n);
    if ((n >> OutLenW) != '0) begin
      return '1;
    end else begin
      return OutLenW'(n);
    end
  endfunction

  function automatic fq_line_e fq_next(input fq_line_e l);
    fq_line_e r;
    unique case (l)
      FQ_HEADER: r = FQ_SEQ;
      FQ_SEQ:    r = FQ_PLUS;
      FQ_PLUS:   r = FQ_QUAL;
      FQ_QUAL:   r = FQ_HEADER;
      default:   r = FQ_HEADER;
    endcase
    return r;
  endfunction

endpackage

>>> rtl/ffse_front.sv
// Front end: decode each incoming word into a classified item for the queue.
module ffse_front (
  input  logic          in_valid_i,
  input  logic [7:0]    data_byte_i,
  input  logic          end_of_input_i,
  output logic          in_ready_o,
  input  logic          q_ready_i,
  output logic          push_o,
  output ffse_pkg::item_t item_o
);
  import ffse_pkg::*;

  assign in_ready_o = q_ready_i;
  assign push_o     = in_valid_i && q_ready_i;

  always_comb begin
    item_o.data = data_byte_i;
    item_o.eoi  = end_of_input_i;
    item_o.eol  = (data_byte_i == ChLf) || (data_byte_i == ChCr);
    item_o.gt   = (data_byte_i == ChGt);
    item_o.at   = (data_byte_i == ChAt);
  end

endmodule

>>> rtl/ffse_queue.sv
// Short queue of classified items between front and back.
module ffse_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  ffse_pkg::item_t push_item_i,
  output logic            ready_o,
  input  logic            pop_i,
  output logic            valid_o,
  output ffse_pkg::item_t pop_item_o
);
  import ffse_pkg::*;

  item_t             entries_q [QDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;

  assign ready_o    = (count_q != QCntW'(QDepth));
  assign valid_o    = (count_q != '0);
  assign pop_item_o = entries_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 1'b1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entries_q[wr_ptr_q] <= push_item_i;
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (count_q <= QCntW'(QDepth)))
    else $error("queue fill exceeds its depth");
`endif

endmodule

>>> rtl/ffse_back.sv
// Back end: parser state machine and result register.
module ffse_back (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            q_valid_i,
  input  ffse_pkg::item_t                 item_i,
  output logic                            pop_o,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [7:0]                      base_byte_o,
  output logic [1:0]                      kind_o,
  output logic [ffse_pkg::OutLenW-1:0]    record_length_o,
  output logic [1:0]                      status_o
);
  import ffse_pkg::*;

  logic                  started_q, started_d;
  logic                  is_fastq_q, is_fastq_d;
  logic                  error_hold_q, error_hold_d;
  fa_phase_e             phase_q, phase_d;
  fq_line_e              line_q, line_d;
  logic                  prev_eol_q, prev_eol_d;
  logic [LengthBits-1:0] count_q, count_d;
  action_t               act;

  logic                  out_valid_q, out_valid_d;
  logic [7:0]            byte_q, byte_d;
  kind_e                 kind_q, kind_d;
  logic [OutLenW-1:0]    len_q, len_d;
  status_e               status_q, status_d;

  assign pop_o = q_valid_i && (!out_valid_q || out_ready_i);

  // Next state and the action that the popped word calls for.
  always_comb begin
    logic fq;
    fq           = is_fastq_q;
    started_d    = started_q;
    is_fastq_d   = is_fastq_q;
    error_hold_d = error_hold_q;
    phase_d      = phase_q;
    line_d       = line_q;
    prev_eol_d   = prev_eol_q;
    act          = '{base: 1'b0, rec_end: 1'b0, stat: 1'b0, code: ST_OK};

    if (pop_o) begin
      if (item_i.eoi) begin
        if (!started_q) begin
          act.stat = 1'b1;
          act.code = ST_EMPTY;
        end else if (!error_hold_q) begin
          if (!is_fastq_q) begin
            act.rec_end = 1'b1;
          end else if (line_q == FQ_SEQ && !prev_eol_q) begin
            act.stat = 1'b1;
            act.code = ST_TRUNC;
          end
        end
        started_d    = 1'b0;
        is_fastq_d   = 1'b0;
        error_hold_d = 1'b0;
        phase_d      = PH_HEADER;
        line_d       = FQ_HEADER;
        prev_eol_d   = 1'b0;
      end else if (!error_hold_q) begin
        if (!started_q && !item_i.at && !item_i.gt) begin
          started_d    = 1'b1;
          error_hold_d = 1'b1;
          act.stat     = 1'b1;
          act.code     = ST_UNKNOWN;
        end else begin
          if (!started_q) begin
            started_d  = 1'b1;
            fq         = item_i.at;
            is_fastq_d = item_i.at;
          end
          if (fq) begin
            if (item_i.eol) begin
              if (!prev_eol_q) begin
                act.rec_end = (line_q == FQ_SEQ);
                line_d      = fq_next(line_q);
              end
              prev_eol_d = 1'b1;
            end else begin
              act.base   = (line_q == FQ_SEQ);
              prev_eol_d = 1'b0;
            end
          end else begin
            unique case (phase_q)
              PH_HEADER: begin
                if (item_i.eol) phase_d = PH_EOL_HDR;
              end
              PH_EOL_HDR: begin
                if (!item_i.eol) begin
                  phase_d  = PH_READ;
                  act.base = 1'b1;
                end
              end
              PH_READ: begin
                if (item_i.eol) begin
                  phase_d = PH_EOL_READ;
                end else begin
                  act.base = 1'b1;
                end
              end
              PH_EOL_READ: begin
                if (!item_i.eol) begin
                  if (item_i.gt) begin
                    phase_d     = PH_HEADER;
                    act.rec_end = 1'b1;
                  end else begin
                    phase_d  = PH_READ;
                    act.base = 1'b1;
                  end
                end
              end
              default: phase_d = PH_HEADER;
            endcase
          end
        end
      end
    end

    count_d = count_q;
    if (pop_o && (item_i.eoi || act.rec_end)) begin
      count_d = '0;
    end else if (act.base && count_q != '1) begin
      count_d = count_q + 1'b1;
    end
  end

  // Result formed from the action; hold it while the receiver stalls.
  always_comb begin
    out_valid_d = out_valid_q;
    byte_d      = byte_q;
    kind_d      = kind_q;
    len_d       = len_q;
    status_d    = status_q;
    if (pop_o) begin
      out_valid_d = act.base || act.rec_end || act.stat;
      byte_d      = act.base ? item_i.data : 8'd0;
      len_d       = act.rec_end ? clip_len(count_q) : '0;
      status_d    = act.stat ? act.code : ST_OK;
      priority if (act.stat) begin
        kind_d = KIND_STATUS;
      end else if (act.rec_end) begin
        kind_d = KIND_RECEND;
      end else begin
        kind_d = KIND_BASE;
      end
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      started_q    <= 1'b0;
      is_fastq_q   <= 1'b0;
      error_hold_q <= 1'b0;
      phase_q      <= PH_HEADER;
      line_q       <= FQ_HEADER;
      prev_eol_q   <= 1'b0;
      count_q      <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      started_q    <= started_d;
      is_fastq_q   <= is_fastq_d;
      error_hold_q <= error_hold_d;
      phase_q      <= phase_d;
      line_q       <= line_d;
      prev_eol_q   <= prev_eol_d;
      count_q      <= count_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q   <= byte_d;
    kind_q   <= kind_d;
    len_q    <= len_d;
    status_q <= status_d;
  end

  assign out_valid_o     = out_valid_q;
  assign base_byte_o     = byte_q;
  assign kind_o          = kind_q;
  assign record_length_o = len_q;
  assign status_o        = status_q;

`ifndef SYNTHESIS
  a_eoi_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && item_i.eoi) |=> (count_q == '0 && !started_q && !error_hold_q))
    else $error("end marker did not return the parser to its idle state");

  a_hold_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pop_o && error_hold_q && !item_i.eoi) |=> !out_valid_q)
    else $error("result produced while in error hold");

  a_base_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && kind_q == KIND_BASE) |-> (len_q == '0 && status_q == ST_OK))
    else $error("base word carries a length or status");
`endif

endmodule

>>> rtl/fasta_fastq_sequence_extractor.sv
// Top level of the FASTA/FASTQ sequence extractor: front, queue and back joined.
//
// Usage:
//   Input channel (in_valid_i / in_ready_o) carries one word per file byte in
//   data_byte_i, then one word with end_of_input_i set to close the file.
//   The first byte selects FASTQ ('@') or FASTA ('>').
//   Output channel (out_valid_o / out_ready_i) carries zero or one result per
//   input word: a sequence base, a record end with its saturating length, or
//   a status report (unknown format, empty input, truncated record).
//   Throughput: one word per cycle while out_ready_i is high; the parser state
//   machine in the back end updates once per cycle, so that loop sets the rate.
//   Path: on acceptance the word is written into the two-entry queue, and it
//   is then parsed from the queue into the back end output register.
//   Reset: all parser state clears, the queue empties and no result is shown.
//   Receiver stall: the result register holds its word; the back end stops
//   popping, the queue fills, and in_ready_o drops once both entries are held.
//   The end marker returns the parser to its reset state for the next file.
module fasta_fastq_sequence_extractor (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [7:0]                   data_byte_i,
  input  logic                         end_of_input_i,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [7:0]                   base_byte_o,
  output logic [1:0]                   kind_o,
  output logic [ffse_pkg::OutLenW-1:0] record_length_o,
  output logic [1:0]                   status_o
);
  import ffse_pkg::*;

  item_t push_item;
  item_t pop_item;
  logic  push;
  logic  q_ready;
  logic  q_valid;
  logic  pop;

  // Classify each byte: line end, header marks, end of file.
  ffse_front u_front (
    .in_valid_i     (in_valid_i),
    .data_byte_i    (data_byte_i),
    .end_of_input_i (end_of_input_i),
    .in_ready_o     (in_ready_o),
    .q_ready_i      (q_ready),
    .push_o         (push),
    .item_o         (push_item)
  );

  // Decouple the input from back-end stalls.
  ffse_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .ready_o     (q_ready),
    .pop_i       (pop),
    .valid_o     (q_valid),
    .pop_item_o  (pop_item)
  );

  // Run the record parser and hold each result until it is taken.
  ffse_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .q_valid_i       (q_valid),
    .item_i          (pop_item),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .base_byte_o     (base_byte_o),
    .kind_o          (kind_o),
    .record_length_o (record_length_o),
    .status_o        (status_o)
  );

endmodule
